>>> hw/rtl/efr_pkg.sv
`default_nettype none

package efr_pkg;

    localparam int MAX_PAYLOAD_DEF = 64;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = 2'd2;

    localparam logic [7:0] START_RST  = 8'd2;
    localparam logic [7:0] END_RST    = 8'd3;
    localparam logic [7:0] ESCAPE_RST = 8'd27;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_LEN_HI  = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_TYPE    = 3'd3,
        PH_SUBTYPE = 3'd4,
        PH_BODY    = 3'd5,
        PH_TRAILER = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        CTL_IDLE = 2'd0,
        CTL_READ = 2'd1,
        CTL_LOAD = 2'd2
    } t_ctl;

    typedef enum logic [2:0] {
        ST_PAYLOAD     = 3'd0,
        ST_EMPTY       = 3'd1,
        ST_BAD_SUM     = 3'd2,
        ST_BAD_TRAILER = 3'd3,
        ST_UNEXP_END   = 3'd4,
        ST_RESTART     = 3'd5,
        ST_TOO_LONG    = 3'd6
    } t_status;

endpackage

`default_nettype wire

>>> hw/rtl/escaped_frame_receiver_top.sv
`default_nettype none

// Byte-stuffed frame receiver with an XOR checksum. Each input beat carries one raw line
// byte and is taken whenever the block is not delivering a frame and its output register
// is free. Payload bytes go into a buffer of MAX_PAYLOAD entries with one write port and
// one read port as they arrive. A good frame's end flag starts delivery: each payload beat
// is one buffer read with registered data, then the output register load, so input stays
// stalled until the last payload beat is loaded, plus any output back-pressure.
// Every dropped frame yields one status beat with last set; an empty good frame yields one
// status beat as well. The configuration port is always ready and should be written only
// while the block is idle.
module escaped_frame_receiver_top
    import efr_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [7:0]           i_line_byte,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic      [2:0]           o_status,
    output logic      [15:0]          o_frame_length,
    output logic      [7:0]           o_frame_type,
    output logic      [7:0]           o_frame_subtype,
    output logic      [7:0]           o_payload_byte,
    output logic      [5:0]           o_byte_position,
    output logic                      o_last,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]           i_cfg_data
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [7:0]    r_open_code;
    logic [7:0]    r_close_code;
    logic [7:0]    r_escape;

    t_phase        r_phase,  n_phase;
    t_ctl          r_ctl,    n_ctl;
    logic          r_esc,    n_esc;
    logic [15:0]   r_len,    n_len;
    logic [7:0]    r_type,   n_type;
    logic [7:0]    r_sub,    n_sub;
    logic [7:0]    r_xor,    n_xor;
    logic [6:0]    r_cnt,    n_cnt;
    logic [AW-1:0] r_rd_idx, n_rd_idx;

    logic          r_out_valid,  n_out_valid;
    t_status       r_out_status, n_out_status;
    logic [15:0]   r_out_len,    n_out_len;
    logic [7:0]    r_out_type,   n_out_type;
    logic [7:0]    r_out_sub,    n_out_sub;
    logic [7:0]    r_out_data,   n_out_data;
    logic [5:0]    r_out_pos,    n_out_pos;
    logic          r_out_last,   n_out_last;

    logic          w_accept;
    logic          w_out_free;
    logic          w_wr_en;
    logic          w_rd_en;
    logic [7:0]    w_rd_data;
    logic          w_emit;
    t_status       w_emit_st;
    logic          w_begin;
    logic          w_is_data;
    logic [7:0]    w_data_xor;
    logic          w_last;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_ctl == CTL_IDLE) && w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_code  <= START_RST;
            r_close_code <= END_RST;
            r_escape     <= ESCAPE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_START:  r_open_code  <= i_cfg_data;
                CFG_END:    r_close_code <= i_cfg_data;
                CFG_ESCAPE: r_escape     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    efr_buf #(
        .DEPTH(MAX_PAYLOAD),
        .AW   (AW)
    ) u_buf (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(r_cnt[AW-1:0]),
        .i_wr_data(i_line_byte),
        .i_rd_en  (w_rd_en),
        .i_rd_addr(r_rd_idx),
        .o_rd_data(w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_ctl       <= CTL_IDLE;
            r_esc       <= 1'b0;
            r_len       <= '0;
            r_type      <= '0;
            r_sub       <= '0;
            r_xor       <= '0;
            r_cnt       <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_ctl       <= n_ctl;
            r_esc       <= n_esc;
            r_len       <= n_len;
            r_type      <= n_type;
            r_sub       <= n_sub;
            r_xor       <= n_xor;
            r_cnt       <= n_cnt;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_len    <= n_out_len;
        r_out_type   <= n_out_type;
        r_out_sub    <= n_out_sub;
        r_out_data   <= n_out_data;
        r_out_pos    <= n_out_pos;
        r_out_last   <= n_out_last;
    end

    always_comb begin
        n_phase      = r_phase;
        n_ctl        = r_ctl;
        n_esc        = r_esc;
        n_len        = r_len;
        n_type       = r_type;
        n_sub        = r_sub;
        n_xor        = r_xor;
        n_cnt        = r_cnt;
        n_rd_idx     = r_rd_idx;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_len    = r_out_len;
        n_out_type   = r_out_type;
        n_out_sub    = r_out_sub;
        n_out_data   = r_out_data;
        n_out_pos    = r_out_pos;
        n_out_last   = r_out_last;
        w_wr_en      = 1'b0;
        w_rd_en      = 1'b0;
        w_emit       = 1'b0;
        w_emit_st    = ST_PAYLOAD;
        w_begin      = 1'b0;
        w_is_data    = 1'b0;
        w_data_xor   = r_xor ^ i_line_byte;
        w_last       = (16'(r_rd_idx) + 16'd1) == r_len;

        case (r_ctl)
            CTL_IDLE: begin
                if (w_accept) begin
                    case (r_phase)
                        PH_HUNT: begin
                            if (i_line_byte == r_open_code) begin
                                w_begin = 1'b1;
                            end
                        end
                        PH_TRAILER: begin
                            n_phase = PH_HUNT;
                            n_esc   = 1'b0;
                            if (i_line_byte != r_close_code) begin
                                w_emit    = 1'b1;
                                w_emit_st = ST_BAD_TRAILER;
                            end else if (r_len == 16'd0) begin
                                w_emit    = 1'b1;
                                w_emit_st = ST_EMPTY;
                            end else begin
                                n_ctl    = CTL_READ;
                                n_rd_idx = '0;
                            end
                        end
                        PH_LEN_HI, PH_LEN_LO, PH_TYPE, PH_SUBTYPE, PH_BODY: begin
                            if (r_esc) begin
                                n_esc     = 1'b0;
                                w_is_data = 1'b1;
                            end else if (i_line_byte == r_escape) begin
                                n_esc = 1'b1;
                            end else if (i_line_byte == r_open_code) begin
                                w_emit    = 1'b1;
                                w_emit_st = ST_RESTART;
                                w_begin   = 1'b1;
                            end else if (i_line_byte == r_close_code) begin
                                w_emit    = 1'b1;
                                w_emit_st = ST_UNEXP_END;
                                n_phase   = PH_HUNT;
                            end else begin
                                w_is_data = 1'b1;
                            end
                        end
                        default: begin
                            n_phase = PH_HUNT;
                        end
                    endcase

                    if (w_is_data) begin
                        n_xor = w_data_xor;
                        case (r_phase)
                            PH_LEN_HI: begin
                                n_len   = {i_line_byte, 8'd0};
                                n_phase = PH_LEN_LO;
                            end
                            PH_LEN_LO: begin
                                n_len = {r_len[15:8], i_line_byte};
                                if (n_len > 16'(MAX_PAYLOAD)) begin
                                    w_emit    = 1'b1;
                                    w_emit_st = ST_TOO_LONG;
                                    n_phase   = PH_HUNT;
                                    n_esc     = 1'b0;
                                end else begin
                                    n_phase = PH_TYPE;
                                end
                            end
                            PH_TYPE: begin
                                n_type  = i_line_byte;
                                n_phase = PH_SUBTYPE;
                            end
                            PH_SUBTYPE: begin
                                n_sub   = i_line_byte;
                                n_cnt   = '0;
                                n_phase = PH_BODY;
                            end
                            PH_BODY: begin
                                w_wr_en = {9'd0, r_cnt} < r_len;
                                n_cnt   = r_cnt + 7'd1;
                                if ({9'd0, n_cnt} == (r_len + 16'd1)) begin
                                    if (w_data_xor != 8'd0) begin
                                        w_emit    = 1'b1;
                                        w_emit_st = ST_BAD_SUM;
                                        n_phase   = PH_HUNT;
                                        n_esc     = 1'b0;
                                    end else begin
                                        n_phase = PH_TRAILER;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end

                    if (w_emit) begin
                        n_out_valid  = 1'b1;
                        n_out_status = w_emit_st;
                        n_out_len    = n_len;
                        n_out_type   = n_type;
                        n_out_sub    = n_sub;
                        n_out_data   = 8'd0;
                        n_out_pos    = 6'd0;
                        n_out_last   = 1'b1;
                    end

                    if (w_begin) begin
                        n_phase = PH_LEN_HI;
                        n_esc   = 1'b0;
                        n_len   = '0;
                        n_type  = '0;
                        n_sub   = '0;
                        n_xor   = '0;
                        n_cnt   = '0;
                    end
                end
            end
            CTL_READ: begin
                if (w_out_free) begin
                    w_rd_en = 1'b1;
                    n_ctl   = CTL_LOAD;
                end
            end
            CTL_LOAD: begin
                n_out_valid  = 1'b1;
                n_out_status = ST_PAYLOAD;
                n_out_len    = r_len;
                n_out_type   = r_type;
                n_out_sub    = r_sub;
                n_out_data   = w_rd_data;
                n_out_pos    = 6'(r_rd_idx);
                n_out_last   = w_last;
                if (w_last) begin
                    n_ctl = CTL_IDLE;
                end else begin
                    n_rd_idx = r_rd_idx + AW'(1);
                    n_ctl    = CTL_READ;
                end
            end
            default: begin
                n_ctl = CTL_IDLE;
            end
        endcase
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_frame_length  = r_out_len;
    assign o_frame_type    = r_out_type;
    assign o_frame_subtype = r_out_sub;
    assign o_payload_byte  = r_out_data;
    assign o_byte_position = r_out_pos;
    assign o_last          = r_out_last;

    a_no_write_in_delivery: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl != CTL_IDLE) |-> !w_wr_en)
        else $error("Payload buffer written during delivery.");

    a_load_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl == CTL_LOAD) |=> (r_out_valid && r_out_status == ST_PAYLOAD))
        else $error("Buffer read did not reach the output register.");

    a_length_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY || r_phase == PH_TRAILER || r_ctl != CTL_IDLE)
        |-> (r_len <= 16'(MAX_PAYLOAD)))
        else $error("Frame length exceeds the buffer while it is in use.");

    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> (r_out_status == ST_PAYLOAD))
        else $error("Status beat without last.");

    a_read_before_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl == CTL_LOAD) |-> $past(w_rd_en))
        else $error("Output loaded without a preceding buffer read.");

endmodule

`default_nettype wire

>>> hw/rtl/efr_buf.sv
`default_nettype none

module efr_buf #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [7:0]    i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire
